@@ src/pffm_pkg.sv @@
// Shared types, constants and helper functions for the partition first-fit matcher.
// Depends on nothing; every other file of the block but pffm_ram imports it.
package pffm_pkg;

  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_NODE_BITS   = 64;

  localparam int SLOT_W  = 4;
  localparam int CNT_W   = 7;
  localparam int PROCS_W = 17;
  localparam int SEL_W   = 2;
  localparam int GEO_W   = 4;
  localparam int ATTR_W  = CNT_W + 2 + 3 * GEO_W;

  // Attribute word layout: count, connection bit, mode bit, then X, Y, Z.
  localparam int A_CONN = CNT_W;
  localparam int A_USE  = CNT_W + 1;
  localparam int A_GX   = CNT_W + 2;
  localparam int A_GY   = A_GX + GEO_W;
  localparam int A_GZ   = A_GY + GEO_W;

  localparam int PROCS_PER_NODE      = 512;
  localparam int PROCS_PER_NODE_VIRT = 1024;
  localparam int PPN_SHIFT           = $clog2(PROCS_PER_NODE);
  localparam int VIRT_SHIFT          = $clog2(PROCS_PER_NODE_VIRT);

  localparam logic [SEL_W-1:0] SEL_ANY = 2'd2;

  typedef enum logic [1:0] {
    KIND_CLEAR     = 2'd0,
    KIND_WRITE     = 2'd1,
    KIND_MATCH_FIX = 2'd2,
    KIND_MATCH_ROT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic take_hit;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_match;
    logic hit;
    logic issued_all;
    logic ev_live;
    logic out_free;
  } ctrl_stat_t;

  // True when the entry shape is at least the request on every axis.
  function automatic logic covers(input logic [GEO_W-1:0] ex, input logic [GEO_W-1:0] ey,
                                  input logic [GEO_W-1:0] ez, input logic [GEO_W-1:0] ra,
                                  input logic [GEO_W-1:0] rb, input logic [GEO_W-1:0] rc);
    return (ex >= ra) && (ey >= rb) && (ez >= rc);
  endfunction

  // Shape test over the plain orientation, or all six axis orders when rotation is allowed.
  function automatic logic shape_fits(input logic [GEO_W-1:0] ex, input logic [GEO_W-1:0] ey,
                                      input logic [GEO_W-1:0] ez, input logic [GEO_W-1:0] rx,
                                      input logic [GEO_W-1:0] ry, input logic [GEO_W-1:0] rz,
                                      input logic rot);
    logic any_rot;
    any_rot = covers(ex, ey, ez, rx, rz, ry) || covers(ex, ey, ez, rz, rx, ry) ||
              covers(ex, ey, ez, rz, ry, rx) || covers(ex, ey, ez, ry, rz, rx) ||
              covers(ex, ey, ez, ry, rx, rz);
    return covers(ex, ey, ez, rx, ry, rz) || (rot && any_rot);
  endfunction

endpackage

@@ src/pffm_if.sv @@
// Valid/ready channel interfaces for the request and result sides of the matcher.
// Depends on pffm_pkg for field widths.
interface pffm_in_if import pffm_pkg::*; #(
  parameter int NODE_BITS = DEF_NODE_BITS
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [SLOT_W-1:0]    slot;
  logic [CNT_W-1:0]     node_count;
  logic [CNT_W-1:0]     node_limit;
  logic [PROCS_W-1:0]   proc_demand;
  logic [SEL_W-1:0]     link_sel;
  logic [SEL_W-1:0]     mode_sel;
  logic [GEO_W-1:0]     geo_x;
  logic [GEO_W-1:0]     geo_y;
  logic [GEO_W-1:0]     geo_z;
  logic [NODE_BITS-1:0] node_map;
  logic [NODE_BITS-1:0] required_map;

  modport source (
    output valid, kind, slot, node_count, node_limit, proc_demand, link_sel, mode_sel,
           geo_x, geo_y, geo_z, node_map, required_map,
    input  ready
  );
  modport sink (
    input  valid, kind, slot, node_count, node_limit, proc_demand, link_sel, mode_sel,
           geo_x, geo_y, geo_z, node_map, required_map,
    output ready
  );
endinterface

interface pffm_out_if import pffm_pkg::*; #(
  parameter int NODE_BITS = DEF_NODE_BITS
);
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [SLOT_W-1:0]    match_slot;
  logic [NODE_BITS-1:0] granted_map;

  modport source (output valid, found, match_slot, granted_map, input ready);
  modport sink (input valid, found, match_slot, granted_map, output ready);
endinterface

@@ src/partition_first_fit_matcher.sv @@
// Top level of the partition first-fit matcher: controller, datapath and checks.
// Depends on pffm_pkg, pffm_if, pffm_ctrl and pffm_dp (which uses pffm_ram).
//
//   Channel   Direction  Handshake          Carries
//   in_ch     in         valid / ready      one request: clear, write entry or placement
//   out_ch    out        valid / ready      one result per request: found, slot, node map
//
// A clear or write request goes straight from idle to the done state, where its result is
// handed to the output register. A placement reads one table row per cycle through the
// single read port of the table RAM and stops at the first hit, or after the last row.
// Reset only clears the per-entry valid bits and the control state; the table rows are
// undefined until written, so there is no clearing pass.
// Requests are taken only while the controller is idle. A result waits in the output
// register while the next request is accepted and processed; that request finishes only
// once the register has been emptied.
module partition_first_fit_matcher import pffm_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int NODE_BITS   = DEF_NODE_BITS
) (
  input logic         clk,
  input logic         rst_n,
  pffm_in_if.sink     in_ch,
  pffm_out_if.source  out_ch
);

  // The controller and datapath talk only through these two structs.
  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  logic       in_ready;

  pffm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pffm_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .NODE_BITS   (NODE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_ch.kind),
    .in_slot         (in_ch.slot),
    .in_node_count   (in_ch.node_count),
    .in_node_limit   (in_ch.node_limit),
    .in_proc_demand  (in_ch.proc_demand),
    .in_link_sel     (in_ch.link_sel),
    .in_mode_sel     (in_ch.mode_sel),
    .in_geo_x        (in_ch.geo_x),
    .in_geo_y        (in_ch.geo_y),
    .in_geo_z        (in_ch.geo_z),
    .in_node_map     (in_ch.node_map),
    .in_required_map (in_ch.required_map),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_found       (out_ch.found),
    .out_match_slot  (out_ch.match_slot),
    .out_granted_map (out_ch.granted_map)
  );

  assign in_ch.ready = in_ready;

  // A placement always starts with an empty pipeline and a fresh scan counter.
  a_scan_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && stat.is_match |=> !stat.ev_live && !stat.issued_all)
    else $error("placement scan did not start from a clean state");

  // Once a hit has been taken, no further table rows are read.
  a_stop_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_hit |=> !cmd.issue)
    else $error("table read issued after a hit");

  // Handing a result over always leaves it presented on the output.
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_ch.valid)
    else $error("emitted result not presented");

  // A result without a match carries neither a slot nor any nodes.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.found |-> (out_ch.match_slot == '0) && (out_ch.granted_map == '0))
    else $error("miss result carries a slot or node map");

endmodule

@@ src/pffm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module pffm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/pffm_ctrl.sv @@
// Controller state machine of the matcher: sequences accept, table scan and result hand-off.
// Depends on pffm_pkg for the state, command and status types.
module pffm_ctrl import pffm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.is_match ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (stat.hit) begin
          cmd.take_hit = 1'b1;
          state_nxt    = ST_DONE;
        end else begin
          cmd.issue = !stat.issued_all;
          if (stat.issued_all && !stat.ev_live) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/pffm_dp.sv @@
// Datapath of the matcher: partition table, request registers, entry tests and result register.
// Depends on pffm_pkg and instantiates pffm_ram for the table rows.
module pffm_dp import pffm_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int NODE_BITS   = DEF_NODE_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_cmd_t            cmd,
  output ctrl_stat_t           stat,
  input  logic [1:0]           in_kind,
  input  logic [SLOT_W-1:0]    in_slot,
  input  logic [CNT_W-1:0]     in_node_count,
  input  logic [CNT_W-1:0]     in_node_limit,
  input  logic [PROCS_W-1:0]   in_proc_demand,
  input  logic [SEL_W-1:0]     in_link_sel,
  input  logic [SEL_W-1:0]     in_mode_sel,
  input  logic [GEO_W-1:0]     in_geo_x,
  input  logic [GEO_W-1:0]     in_geo_y,
  input  logic [GEO_W-1:0]     in_geo_z,
  input  logic [NODE_BITS-1:0] in_node_map,
  input  logic [NODE_BITS-1:0] in_required_map,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_found,
  output logic [SLOT_W-1:0]    out_match_slot,
  output logic [NODE_BITS-1:0] out_granted_map
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ROW_W = ATTR_W + NODE_BITS;
  localparam int TGT_W = 3 * GEO_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  // Request registers, loaded when an item is accepted.
  logic                 rot_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     maxn_r;
  logic [PROCS_W-1:0]   procs_r;
  logic [SEL_W-1:0]     conn_r;
  logic [SEL_W-1:0]     use_r;
  logic [GEO_W-1:0]     gx_r;
  logic [GEO_W-1:0]     gy_r;
  logic [GEO_W-1:0]     gz_r;
  logic [2*GEO_W-1:0]   gxy_r;
  logic                 geo_zero_r;
  logic [NODE_BITS-1:0] avail_r;
  logic [NODE_BITS-1:0] reqm_r;

  // Scan control.
  logic             valid_r [TABLE_DEPTH];
  logic [IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic             issued_all_r, issued_all_nxt;
  logic             ev_live_r, ev_live_nxt;
  logic [IDX_W-1:0] ev_idx_r;

  // Result holding and output registers.
  logic                 res_found_r;
  logic [SLOT_W-1:0]    res_slot_r;
  logic [NODE_BITS-1:0] res_map_r;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic [NODE_BITS-1:0] out_map_r;

  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [ATTR_W-1:0]    wr_attr;
  logic [ROW_W-1:0]     row_q;
  logic [ATTR_W-1:0]    e_attr;
  logic [NODE_BITS-1:0] e_map;
  logic [CNT_W-1:0]     e_cnt;
  logic                 e_conn;
  logic                 e_use;
  logic [PROCS_W-1:0]   cap;
  logic [TGT_W-1:0]     prod;
  logic [TGT_W-1:0]     target;
  logic                 proc_ok, count_ok, avail_ok, req_ok, type_ok, use_ok, shape_ok;

  // ---------------------------------------------------------------- table write
  assign wr_en   = cmd.accept && (in_kind == KIND_WRITE) && (int'(in_slot) < TABLE_DEPTH);
  assign wr_idx  = IDX_W'(in_slot);
  assign wr_attr = {in_geo_z, in_geo_y, in_geo_x, in_mode_sel[0], in_link_sel[0],
                    in_node_count};

  pffm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata ({in_node_map, wr_attr}),
    .re    (cmd.issue),
    .raddr (scan_idx_r),
    .rdata (row_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (cmd.accept && (in_kind == KIND_CLEAR)) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (wr_en) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- request capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rot_r      <= (in_kind == KIND_MATCH_ROT);
      cnt_r      <= in_node_count;
      maxn_r     <= in_node_limit;
      procs_r    <= in_proc_demand;
      conn_r     <= in_link_sel;
      use_r      <= in_mode_sel;
      gx_r       <= in_geo_x;
      gy_r       <= in_geo_y;
      gz_r       <= in_geo_z;
      gxy_r      <= (2*GEO_W)'(in_geo_x) * (2*GEO_W)'(in_geo_y);
      geo_zero_r <= (in_geo_x == '0) || (in_geo_y == '0) || (in_geo_z == '0);
      avail_r    <= in_node_map;
      reqm_r     <= in_required_map;
    end
  end

  // ---------------------------------------------------------------- scan counter
  always_comb begin
    scan_idx_nxt   = scan_idx_r;
    issued_all_nxt = issued_all_r;
    ev_live_nxt    = cmd.issue;
    if (cmd.accept) begin
      scan_idx_nxt   = '0;
      issued_all_nxt = 1'b0;
      ev_live_nxt    = 1'b0;
    end else if (cmd.issue) begin
      scan_idx_nxt = scan_idx_r + IDX_W'(1);
      if (scan_idx_r == LAST_IDX) begin
        issued_all_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r   <= '0;
      issued_all_r <= 1'b0;
      ev_live_r    <= 1'b0;
    end else begin
      scan_idx_r   <= scan_idx_nxt;
      issued_all_r <= issued_all_nxt;
      ev_live_r    <= ev_live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      ev_idx_r <= scan_idx_r;
    end
  end

  // ---------------------------------------------------------------- entry tests
  assign e_attr = row_q[ATTR_W-1:0];
  assign e_map  = row_q[ROW_W-1:ATTR_W];
  assign e_cnt  = e_attr[CNT_W-1:0];
  assign e_conn = e_attr[A_CONN];
  assign e_use  = e_attr[A_USE];

  assign cap     = e_use ? (PROCS_W'(e_cnt) << VIRT_SHIFT) : (PROCS_W'(e_cnt) << PPN_SHIFT);
  assign proc_ok = (procs_r <= PROCS_W'(PROCS_PER_NODE)) || (procs_r <= cap);

  assign prod     = TGT_W'(gxy_r) * TGT_W'(gz_r);
  assign target   = geo_zero_r ? TGT_W'(cnt_r) : prod;
  assign count_ok = (e_cnt >= cnt_r) && ((maxn_r == '0) || (e_cnt <= maxn_r)) &&
                    (TGT_W'(e_cnt) >= target);

  assign avail_ok = ((e_map & ~avail_r) == '0);
  assign req_ok   = ((reqm_r & ~e_map) == '0);
  assign type_ok  = (conn_r == SEL_ANY) || (conn_r == SEL_W'(e_conn));
  assign use_ok   = (use_r == SEL_ANY) || (use_r == SEL_W'(e_use));
  assign shape_ok = (gx_r == '0) ||
                    shape_fits(e_attr[A_GX +: GEO_W], e_attr[A_GY +: GEO_W],
                               e_attr[A_GZ +: GEO_W], gx_r, gy_r, gz_r, rot_r);

  assign stat.hit = ev_live_r && valid_r[ev_idx_r] && proc_ok && count_ok && avail_ok &&
                    req_ok && type_ok && use_ok && shape_ok;
  assign stat.is_match   = (in_kind == KIND_MATCH_FIX) || (in_kind == KIND_MATCH_ROT);
  assign stat.issued_all = issued_all_r;
  assign stat.ev_live    = ev_live_r;
  assign stat.out_free   = !out_valid_r || out_ready;

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_found_r <= 1'b0;
      res_slot_r  <= '0;
      res_map_r   <= '0;
    end else if (cmd.take_hit) begin
      res_found_r <= 1'b1;
      res_slot_r  <= SLOT_W'(ev_idx_r);
      res_map_r   <= avail_r & e_map;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_found_r <= res_found_r;
      out_slot_r  <= res_slot_r;
      out_map_r   <= res_map_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_match_slot  = out_slot_r;
  assign out_granted_map = out_map_r;

endmodule
